### hw/rtl/csi_pkg.sv
// Shared types and constants for the CSI escape sequence parser.
// Used by csi_ctrl, csi_dp and the csi_escape_sequence_parser top level.
`default_nettype none

package csi_pkg;

	// Byte codes of the terminal stream.
	localparam logic [7:0] CH_ESC      = 8'h1B;
	localparam logic [7:0] CH_BRACKET  = 8'h5B;
	localparam logic [7:0] CH_SEMI     = 8'h3B;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;
	localparam logic [7:0] FINAL_LO    = 8'h40;
	localparam logic [7:0] FINAL_HI    = 8'h7E;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_ARG       = 3'd0,
		ST_PLAIN     = 3'd1,
		ST_NOBRACKET = 3'd2,
		ST_TOOMANY   = 3'd3,
		ST_BADFINAL  = 3'd4
	} csi_status_t;

	// Source of the payload loaded into the output register.
	typedef enum logic [1:0] {
		SRC_NONE,
		SRC_PLAIN_IN,
		SRC_PLAIN_HELD,
		SRC_ARG
	} csi_src_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_ESC,
		S_CSI,
		S_PLAIN,
		S_ARG_RD,
		S_ARG_OUT
	} csi_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic        take;
		logic        clr_args;
		logic        acc_digit;
		logic        push_arg;
		logic        rd_arg;
		logic        emit_inc;
		logic        out_load;
		csi_src_t    out_src;
		csi_status_t out_code;
		logic        out_last;
	} csi_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
		logic full;
		logic emit_last;
		logic is_esc;
		logic is_bracket;
		logic is_digit;
		logic is_semi;
		logic is_final;
	} csi_stat_t;

endpackage

`default_nettype wire

### hw/rtl/csi_ctrl.sv
// Controller state machine of the CSI escape sequence parser.
// Depends on csi_pkg; drives the commands of csi_dp and the input stall.
`default_nettype none

module csi_ctrl
	import csi_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire csi_stat_t stat,
	output csi_cmd_t       cmd
);

	csi_state_t state_q;
	csi_state_t state_nxt;
	logic       parse_state;
	logic       take;

	// Input bytes are taken only in the parsing states with room at the output.
	assign parse_state = (state_q == S_IDLE) || (state_q == S_ESC) || (state_q == S_CSI);
	assign in_stall    = !(parse_state && stat.out_free);
	assign take        = in_valid && !in_stall;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (take && stat.is_esc) begin
					state_nxt = S_ESC;
				end
			end
			S_ESC: begin
				if (take) begin
					if (stat.is_bracket) begin
						state_nxt = S_CSI;
					end else if (stat.is_esc) begin
						state_nxt = S_ESC;
					end else begin
						state_nxt = S_PLAIN;
					end
				end
			end
			S_CSI: begin
				if (take && !stat.is_digit) begin
					if (stat.full) begin
						state_nxt = S_IDLE;
					end else if (stat.is_semi) begin
						state_nxt = S_CSI;
					end else if (stat.is_final) begin
						state_nxt = S_ARG_RD;
					end else begin
						state_nxt = S_IDLE;
					end
				end
			end
			S_PLAIN: begin
				if (stat.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			S_ARG_RD: begin
				state_nxt = S_ARG_OUT;
			end
			S_ARG_OUT: begin
				if (stat.out_free) begin
					state_nxt = stat.emit_last ? S_IDLE : S_ARG_RD;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// Command outputs.
	always_comb begin
		cmd           = '0;
		cmd.take      = take;
		cmd.out_src   = SRC_NONE;
		cmd.out_code  = ST_ARG;
		case (state_q)
			S_IDLE: begin
				if (take && !stat.is_esc) begin
					cmd.out_load = 1'b1;
					cmd.out_src  = SRC_PLAIN_IN;
					cmd.out_code = ST_PLAIN;
					cmd.out_last = 1'b1;
				end
			end
			S_ESC: begin
				if (take) begin
					if (stat.is_bracket) begin
						cmd.clr_args = 1'b1;
					end else begin
						// A following ESC opens a new sequence, so it closes the results.
						cmd.out_load = 1'b1;
						cmd.out_code = ST_NOBRACKET;
						cmd.out_last = stat.is_esc;
					end
				end
			end
			S_CSI: begin
				if (take) begin
					if (stat.is_digit) begin
						cmd.acc_digit = 1'b1;
					end else if (stat.full) begin
						cmd.out_load = 1'b1;
						cmd.out_code = ST_TOOMANY;
						cmd.out_last = 1'b1;
					end else begin
						cmd.push_arg = 1'b1;
						if (!stat.is_semi && !stat.is_final) begin
							cmd.out_load = 1'b1;
							cmd.out_code = ST_BADFINAL;
							cmd.out_last = 1'b1;
						end
					end
				end
			end
			S_PLAIN: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_src  = SRC_PLAIN_HELD;
					cmd.out_code = ST_PLAIN;
					cmd.out_last = 1'b1;
				end
			end
			S_ARG_RD: begin
				cmd.rd_arg = 1'b1;
			end
			S_ARG_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_src  = SRC_ARG;
					cmd.out_code = ST_ARG;
					cmd.out_last = stat.emit_last;
					cmd.emit_inc = !stat.emit_last;
				end
			end
			default: begin
				cmd.take = 1'b0;
			end
		endcase
	end

	// A read of the argument store is always followed by its emission.
	a_rd_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ARG_RD |=> state_q == S_ARG_OUT)
		else $error("argument read not followed by emission");

	// No byte is taken while results of the previous one are still being produced.
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PLAIN || state_q == S_ARG_RD || state_q == S_ARG_OUT) |-> in_stall)
		else $error("input taken while emitting");

	// An argument is never stored into a full store.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_arg |-> !stat.full)
		else $error("argument pushed into full store");

endmodule

`default_nettype wire

### hw/rtl/csi_dp.sv
// Datapath of the CSI escape sequence parser: byte decode, argument
// accumulator, argument store and output register. Depends on csi_pkg.
`default_nettype none

module csi_dp
	import csi_pkg::*;
#(
	parameter int MAX_ARGS  = 16,
	parameter int ARG_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  byte_in,
	input  wire csi_cmd_t    cmd,
	output csi_stat_t        stat,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [7:0]       plain_byte,
	output logic [7:0]       final_kind,
	output logic [15:0]      arg_value,
	output logic [3:0]       arg_index,
	output logic             last
);

	localparam int IDX_W = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
	localparam int CNT_W = $clog2(MAX_ARGS + 1);

	logic [ARG_WIDTH-1:0] cur_q;
	logic [CNT_W-1:0]     count_q;
	logic [IDX_W-1:0]     emit_idx_q;
	logic [7:0]           hold_q;
	logic [ARG_WIDTH-1:0] arg_mem [MAX_ARGS];
	logic [ARG_WIDTH-1:0] rdata_q;

	logic                 out_valid_q;
	csi_status_t          status_q;
	logic [7:0]           plain_q;
	logic [7:0]           final_q;
	logic [15:0]          value_q;
	logic [3:0]           index_q;
	logic                 last_q;

	logic [7:0]           digit_off;
	logic [ARG_WIDTH+3:0] prod;
	logic [ARG_WIDTH-1:0] cur_sat;
	logic [ARG_WIDTH+15:0] rdata_ext;
	logic [IDX_W+3:0]     idx_ext;

	// Byte decode.
	assign digit_off       = byte_in - CH_ZERO;
	assign stat.is_esc     = (byte_in == CH_ESC);
	assign stat.is_bracket = (byte_in == CH_BRACKET);
	assign stat.is_semi    = (byte_in == CH_SEMI);
	assign stat.is_digit   = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
	assign stat.is_final   = (byte_in >= FINAL_LO) && (byte_in <= FINAL_HI);

	// Store occupancy and emission position.
	assign stat.full      = (count_q == CNT_W'(MAX_ARGS));
	assign stat.emit_last = ((CNT_W'(emit_idx_q) + CNT_W'(1)) == count_q);
	assign stat.out_free  = !out_valid_q || !out_stall;

	// Decimal accumulate: value times ten plus the digit, saturated.
	assign prod = {1'b0, cur_q, 3'b000} + {3'b000, cur_q, 1'b0}
		+ {ARG_WIDTH'(0), digit_off[3:0]};
	assign cur_sat = (|prod[ARG_WIDTH+3:ARG_WIDTH]) ? {ARG_WIDTH{1'b1}} : prod[ARG_WIDTH-1:0];

	// Argument accumulator, count and emission index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q      <= '0;
			count_q    <= '0;
			emit_idx_q <= '0;
		end else begin
			if (cmd.clr_args) begin
				cur_q      <= '0;
				count_q    <= '0;
				emit_idx_q <= '0;
			end else begin
				if (cmd.acc_digit) begin
					cur_q <= cur_sat;
				end else if (cmd.push_arg) begin
					cur_q   <= '0;
					count_q <= count_q + CNT_W'(1);
				end
				if (cmd.emit_inc) begin
					emit_idx_q <= emit_idx_q + IDX_W'(1);
				end
			end
		end
	end

	// Last accepted byte: the held plain byte or the final byte of a sequence.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			hold_q <= byte_in;
		end
	end

	// Argument store with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.push_arg) begin
			arg_mem[count_q[IDX_W-1:0]] <= cur_q;
		end
		if (cmd.rd_arg) begin
			rdata_q <= arg_mem[emit_idx_q];
		end
	end

	assign rdata_ext = {16'h0000, rdata_q};
	assign idx_ext   = {4'h0, emit_idx_q};

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status_q <= cmd.out_code;
			last_q   <= cmd.out_last;
			plain_q  <= 8'h00;
			final_q  <= 8'h00;
			value_q  <= 16'h0000;
			index_q  <= 4'h0;
			case (cmd.out_src)
				SRC_PLAIN_IN: begin
					plain_q <= byte_in;
				end
				SRC_PLAIN_HELD: begin
					plain_q <= hold_q;
				end
				SRC_ARG: begin
					final_q <= hold_q;
					value_q <= rdata_ext[15:0];
					index_q <= idx_ext[3:0];
				end
				default: begin
					plain_q <= 8'h00;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign plain_byte = plain_q;
	assign final_kind = final_q;
	assign arg_value  = value_q;
	assign arg_index  = index_q;
	assign last       = last_q;

	// The output register is never overwritten while a result waits.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("output register overwritten");

	// The store never holds more than its depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ARGS))
		else $error("argument count out of range");

	// Only stored arguments are read back.
	a_read_stored: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_arg |-> (CNT_W'(emit_idx_q) < count_q))
		else $error("read of an argument not stored");

endmodule

`default_nettype wire

### hw/rtl/csi_escape_sequence_parser.sv
// Top level of the CSI escape sequence parser: controller and datapath.
// Depends on csi_pkg, csi_ctrl and csi_dp.
//
//   Channel  Direction  Handshake           Payload
//   input    in         in_valid/in_stall   byte_in
//   output   out        out_valid/out_stall status, plain_byte, final_kind,
//                                           arg_value, arg_index, last
//
// A byte that yields at most one result is taken when the output register is
// free or being emptied. ESC followed by a plain byte yields a no-bracket
// result and then the plain byte. After a final byte, each stored argument is
// read from the single read port of the argument store and then emitted.
// Reset clears the controller, argument count and output valid; the argument
// store is not cleared. Output stall holds the result and stalls the input.
`default_nettype none

module csi_escape_sequence_parser
	import csi_pkg::*;
#(
	parameter int MAX_ARGS  = 16,
	parameter int ARG_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  byte_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [7:0]       plain_byte,
	output logic [7:0]       final_kind,
	output logic [15:0]      arg_value,
	output logic [3:0]       arg_index,
	output logic             last
);

	csi_cmd_t  cmd;
	csi_stat_t stat;

	// Sequencing of each transaction.
	csi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Decode, argument storage and output register.
	csi_dp #(
		.MAX_ARGS  (MAX_ARGS),
		.ARG_WIDTH (ARG_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_in    (byte_in),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.plain_byte (plain_byte),
		.final_kind (final_kind),
		.arg_value  (arg_value),
		.arg_index  (arg_index),
		.last       (last)
	);

endmodule

`default_nettype wire
